// ===== rtl/atla_pkg.sv =====
// Package for the ADC triplet leaky averager: widths, lane state types and lane masks.
// Used by the channel interfaces, the lane datapath and the top level.
// No dependencies.
package atla_pkg;

  // Fixed field widths and the filter settings
  localparam int NUM_SLOTS     = 64;
  localparam int AVG_SHIFT     = 5;
  localparam int CODE_BITS     = 12;
  localparam int LANES         = 3;
  localparam int SLOT_BITS     = 6;
  localparam int SLOT_IDX_BITS = $clog2(NUM_SLOTS);
  localparam int AVG_BITS      = CODE_BITS + 1;
  localparam int SUM_BITS      = AVG_BITS + AVG_SHIFT;

  typedef logic [LANES-1:0] lane_mask_t;

  // Lane masks
  localparam lane_mask_t ALL_LANES  = {LANES{1'b1}};
  localparam lane_mask_t LANE0_ONLY = lane_mask_t'(1);

  // Stored state of one lane
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [AVG_BITS-1:0] avg;
  } lane_state_t;

  // One memory word holds all lanes of a slot
  typedef lane_state_t [LANES-1:0] slot_state_t;

endpackage

// ===== rtl/atla_if.sv =====
// Valid/ready channel interfaces for the averager: input request and result.
// Depends on atla_pkg for field widths.

interface atla_in_if;
  logic                              valid;
  logic                              ready;
  logic [atla_pkg::SLOT_BITS-1:0]    slot;
  logic                              is_triplet;
  logic [atla_pkg::CODE_BITS-1:0]    code_lane0;
  logic [atla_pkg::CODE_BITS-1:0]    code_lane1;
  logic [atla_pkg::CODE_BITS-1:0]    code_lane2;
  logic [atla_pkg::LANES-1:0]        code_ok;

  modport source (
    output valid, slot, is_triplet, code_lane0, code_lane1, code_lane2, code_ok,
    input  ready
  );
  modport sink (
    input  valid, slot, is_triplet, code_lane0, code_lane1, code_lane2, code_ok,
    output ready
  );
endinterface

interface atla_out_if;
  logic                              valid;
  logic                              ready;
  logic [atla_pkg::SLOT_BITS-1:0]    out_slot;
  logic [atla_pkg::AVG_BITS-1:0]     average_lane0;
  logic [atla_pkg::AVG_BITS-1:0]     average_lane1;
  logic [atla_pkg::AVG_BITS-1:0]     average_lane2;
  logic [atla_pkg::LANES-1:0]        average_ok;

  modport source (
    output valid, out_slot, average_lane0, average_lane1, average_lane2, average_ok,
    input  ready
  );
  modport sink (
    input  valid, out_slot, average_lane0, average_lane1, average_lane2, average_ok,
    output ready
  );
endinterface

// ===== rtl/adc_triplet_leaky_averager_unit.sv =====
// Top level of the ADC triplet leaky averager: state memory, lane valid flags,
// input stage and result register. Depends on atla_pkg, atla_if, atla_lane.

// A bank of per-slot exponential moving averagers, three lanes per slot.
// One request is accepted every clock cycle unless the output stalls. The
// accepting edge reads the slot's sums and averages from the state memory into
// the input stage register, which then computes the update, writes it back and
// loads the result register when that is free. The memory takes one read and
// one write per cycle at separate addresses (simple dual port).
// Back-to-back requests to the same slot are served from a forwarding register,
// so there is no stall.
// The rate is set by that one read-modify-write of the state memory per
// request. Per-lane valid flags are flip-flops cleared by reset, so the block
// is ready right after reset with no clearing pass. Averages of lanes without
// a value read as zero.
module adc_triplet_leaky_averager_unit (
  input  logic         clk,
  input  logic         rst,
  atla_in_if.sink      in_ch,
  atla_out_if.source   out_ch
);

  localparam int LN = atla_pkg::LANES;
  localparam int IB = atla_pkg::SLOT_IDX_BITS;

  // State storage
  atla_pkg::slot_state_t mem [atla_pkg::NUM_SLOTS];
  atla_pkg::lane_mask_t  has_value [atla_pkg::NUM_SLOTS];

  // Input stage
  logic                              s1_v;
  logic [atla_pkg::SLOT_BITS-1:0]    s1_slot;
  logic                              s1_triplet;
  logic [atla_pkg::CODE_BITS-1:0]    s1_code [LN];
  atla_pkg::lane_mask_t              s1_ok;
  atla_pkg::slot_state_t             rd_data;
  logic                              fwd_hit;
  atla_pkg::slot_state_t             fwd_data;

  // Result register
  logic                              res_v;
  logic [atla_pkg::SLOT_BITS-1:0]    res_slot;
  logic [atla_pkg::AVG_BITS-1:0]     res_avg [LN];
  atla_pkg::lane_mask_t              res_ok;

  // Stage 1 logic
  logic                              in_accept;
  logic                              s1_adv;
  logic                              in_range;
  logic [IB-1:0]                     s1_idx;
  atla_pkg::lane_mask_t              valid_old;
  atla_pkg::lane_mask_t              valid_next;
  atla_pkg::lane_mask_t              upd;
  atla_pkg::lane_mask_t              show;
  logic                              clr;
  logic                              wr_en;
  atla_pkg::slot_state_t             old_state;
  atla_pkg::slot_state_t             lane_new;
  atla_pkg::slot_state_t             wr_data;
  logic [atla_pkg::AVG_BITS-1:0]     avg_next [LN];
  atla_pkg::lane_mask_t              ok_next;

  // Handshake
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign s1_adv      = s1_v && (!res_v || out_ch.ready);
  assign in_ch.ready = !s1_v || s1_adv;

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_accept) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  // Input stage payload and memory read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_slot    <= in_ch.slot;
      s1_triplet <= in_ch.is_triplet;
      s1_code[0] <= in_ch.code_lane0;
      s1_code[1] <= in_ch.code_lane1;
      s1_code[2] <= in_ch.code_lane2;
      s1_ok      <= in_ch.code_ok;
      rd_data    <= mem[in_ch.slot[IB-1:0]];
      fwd_data   <= wr_data;
    end
  end

  // Forward the word written in the same cycle as a read of that slot
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_accept) begin
      fwd_hit <= wr_en && (in_ch.slot == s1_slot);
    end
  end

  // Lane control
  always_comb begin
    in_range  = {1'b0, s1_slot} < (atla_pkg::SLOT_BITS+1)'(atla_pkg::NUM_SLOTS);
    s1_idx    = s1_slot[IB-1:0];
    valid_old = in_range ? has_value[s1_idx] : '0;
    old_state = fwd_hit ? fwd_data : rd_data;
    if (s1_triplet) begin
      upd  = (s1_ok == atla_pkg::ALL_LANES) ? atla_pkg::ALL_LANES : '0;
      clr  = (s1_ok != atla_pkg::ALL_LANES);
      show = atla_pkg::ALL_LANES;
    end else begin
      upd  = s1_ok & atla_pkg::LANE0_ONLY;
      clr  = 1'b0;
      show = atla_pkg::LANE0_ONLY;
    end
    if (!in_range) begin
      upd  = '0;
      clr  = 1'b0;
      show = '0;
    end
    valid_next = clr ? '0 : (valid_old | upd);
    wr_en      = s1_adv && (upd != '0);
  end

  // Lane datapaths
  for (genvar k = 0; k < LN; k++) begin : g_lane
    atla_lane u_lane (
      .code      (s1_code[k]),
      .has_value (valid_old[k]),
      .old_state (old_state[k]),
      .new_state (lane_new[k])
    );
  end

  // Write-back word and result fields
  always_comb begin
    for (int k = 0; k < LN; k++) begin
      wr_data[k]  = upd[k] ? lane_new[k] : old_state[k];
      ok_next[k]  = show[k] && valid_next[k];
      avg_next[k] = ok_next[k] ? wr_data[k].avg : '0;
    end
  end

  // State memory write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= wr_data;
    end
  end

  // Lane valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < atla_pkg::NUM_SLOTS; i++) begin
        has_value[i] <= '0;
      end
    end else if (s1_adv && in_range) begin
      has_value[s1_idx] <= valid_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (s1_adv) begin
      res_v <= 1'b1;
    end else if (out_ch.ready) begin
      res_v <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_slot <= s1_slot;
      res_avg  <= avg_next;
      res_ok   <= ok_next;
    end
  end

  assign out_ch.valid         = res_v;
  assign out_ch.out_slot      = res_slot;
  assign out_ch.average_lane0 = res_avg[0];
  assign out_ch.average_lane1 = res_avg[1];
  assign out_ch.average_lane2 = res_avg[2];
  assign out_ch.average_ok    = res_ok;

  // Upper lanes only report as part of a complete triplet
  a_triplet_all_or_none: assert property (@(posedge clk) disable iff (rst)
    (res_v && (res_ok[2:1] != 2'b00)) |-> (res_ok == atla_pkg::ALL_LANES))
    else $error("upper lane valid without full triplet");

  // A lane without a value always shows a zero average
  a_invalid_lane_zero: assert property (@(posedge clk) disable iff (rst)
    res_v |-> ((res_ok[0] || res_avg[0] == '0) && (res_ok[1] || res_avg[1] == '0)
               && (res_ok[2] || res_avg[2] == '0)))
    else $error("nonzero average on invalid lane");

  // A read that races a write to the same slot must take the forwarded word
  a_forward_on_race: assert property (@(posedge clk) disable iff (rst)
    (in_accept && wr_en && (in_ch.slot == s1_slot)) |=> (s1_v && fwd_hit))
    else $error("same-slot request missed forwarding");

endmodule

// ===== rtl/atla_lane.sv =====
// One lane of the leaky averager: doubles the code, seeds an empty lane and
// applies the sum update. Pure combinational logic. Depends on atla_pkg.
module atla_lane (
  input  logic [atla_pkg::CODE_BITS-1:0] code,
  input  logic                           has_value,
  input  atla_pkg::lane_state_t          old_state,
  output atla_pkg::lane_state_t          new_state
);

  localparam int SB = atla_pkg::SUM_BITS;
  localparam int SH = atla_pkg::AVG_SHIFT;

  logic [atla_pkg::AVG_BITS-1:0] dcode;
  logic [SB-1:0]                 seed_sum;
  logic [SB-1:0]                 base_sum;
  logic [SB-1:0]                 s;
  logic [SB+SH-1:0]              leak;

  // Seeding then updating gives the same state as seeding alone, so an
  // empty lane simply starts from a seed sum of (2^shift - 1) * dcode.
  always_comb begin
    dcode     = {code, 1'b0};
    seed_sum  = {dcode, {SH{1'b0}}} - SB'(dcode);
    base_sum  = has_value ? old_state.sum : seed_sum;
    s         = base_sum + SB'(dcode);
    leak      = {s, {SH{1'b0}}} - (SB+SH)'(s);
    new_state.sum = leak[SB+SH-1:SH];
    new_state.avg = s[SB-1:SH];
  end

endmodule
